// ===== rtl/anbs_pkg.sv =====
// ----------------------------------------------------------------------------
// anbs_pkg: shared types for the Annex B NAL splitter
// Window, scan state and result list types used by the scan logic, the
// result buffer and the top level.
// ----------------------------------------------------------------------------
package anbs_pkg;

  localparam int WIN_DEPTH = 4;
  localparam int MAX_RES   = 5;
  localparam int CNT_W     = 3;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  typedef struct packed {
    win_t             win;
    logic [CNT_W-1:0] cnt;
    logic             in_nal;
    logic [7:0]       hb;
    logic             hv;
    logic             hf;
  } scan_st_t;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
  } res_t;

  typedef res_t [MAX_RES-1:0] res_list_t;

  typedef struct packed {
    res_list_t        res;
    logic [CNT_W-1:0] nres;
  } res_pack_t;

endpackage

// ===== rtl/anbs_scan.sv =====
// ----------------------------------------------------------------------------
// anbs_scan: start code scan for one input byte
// Combinational next-state and result list for one accepted request,
// including the flush at buffer end.
// ----------------------------------------------------------------------------
module anbs_scan
  import anbs_pkg::*;
(
  input  scan_st_t   st,
  input  logic [7:0] data_byte,
  input  logic       buffer_end,
  output scan_st_t   st_nxt,
  output res_pack_t  res_out
);

  localparam logic [CNT_W-1:0] LEN_POP = CNT_W'(1);
  localparam logic [CNT_W-1:0] LEN_SC3 = CNT_W'(3);
  localparam logic [CNT_W-1:0] LEN_SC4 = CNT_W'(4);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WIN_DEPTH);

  typedef struct packed {
    scan_st_t  st;
    res_pack_t rp;
  } work_t;

  function automatic work_t emit(work_t w, logic [7:0] b, logic first, logic fin);
    if (w.rp.nres < CNT_W'(MAX_RES)) begin
      w.rp.res[w.rp.nres] = '{data: b, first: first, fin: fin};
      w.rp.nres = w.rp.nres + CNT_W'(1);
    end
    return w;
  endfunction

  function automatic work_t drop(work_t w, logic [CNT_W-1:0] k);
    if (k >= w.st.cnt) begin
      w.st.cnt = '0;
    end else begin
      unique case (k)
        LEN_POP: begin
          w.st.win[0] = w.st.win[1];
          w.st.win[1] = w.st.win[2];
          w.st.win[2] = w.st.win[3];
        end
        LEN_SC3: begin
          w.st.win[0] = w.st.win[3];
        end
        default: ;
      endcase
      w.st.cnt = w.st.cnt - k;
    end
    return w;
  endfunction

  function automatic work_t close_nal(work_t w);
    if (w.st.hv) begin
      w = emit(w, w.st.hb, w.st.hf, 1'b1);
    end
    w.st.hv = 1'b0;
    w.st.hf = 1'b0;
    w.st.hb = '0;
    return w;
  endfunction

  function automatic work_t start_code(work_t w, logic [CNT_W-1:0] len);
    w = close_nal(w);
    w.st.in_nal = 1'b1;
    return drop(w, len);
  endfunction

  function automatic work_t pop(work_t w);
    logic first;
    first = !w.st.hv;
    if (w.st.in_nal) begin
      if (w.st.hv) begin
        w = emit(w, w.st.hb, w.st.hf, 1'b0);
      end
      w.st.hb = w.st.win[0];
      w.st.hv = 1'b1;
      w.st.hf = first;
    end
    return drop(w, LEN_POP);
  endfunction

  function automatic logic is_sc3(win_t v);
    return (v[0] == 8'h00) && (v[1] == 8'h00) && (v[2] == 8'h01);
  endfunction

  function automatic logic is_sc4(win_t v);
    return (v[0] == 8'h00) && (v[1] == 8'h00) && (v[2] == 8'h00) && (v[3] == 8'h01);
  endfunction

  always_comb begin
    work_t w;
    w.st = st;
    w.rp = '0;
    // append the new byte; the window never holds more than three between bytes
    w.st.win[st.cnt[1:0]] = data_byte;
    w.st.cnt = st.cnt + CNT_W'(1);

    if (w.st.cnt == CNT_FULL) begin
      if (is_sc3(w.st.win)) begin
        w = start_code(w, LEN_SC3);
      end else if (is_sc4(w.st.win)) begin
        w = start_code(w, LEN_SC4);
      end else begin
        w = pop(w);
      end
    end

    if (buffer_end) begin
      if (w.st.cnt >= LEN_SC3) begin
        if (is_sc3(w.st.win)) begin
          w = start_code(w, LEN_SC3);
        end else begin
          w = pop(w);
        end
      end
      for (int i = 0; i < WIN_DEPTH - 1; i++) begin
        if (w.st.cnt != '0) begin
          w = pop(w);
        end
      end
      w = close_nal(w);
      w.st = '0;
    end

    st_nxt  = w.st;
    res_out = w.rp;
  end

endmodule

// ===== rtl/anbs_outbuf.sv =====
// ----------------------------------------------------------------------------
// anbs_outbuf: result buffer
// Holds the results of one request and hands them out one per cycle unless out_stall.
// ----------------------------------------------------------------------------
module anbs_outbuf
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_pack_t  res_in,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_nal_byte,
  output logic       out_nal_first,
  output logic       out_nal_final,
  output logic       out_run_last
);

  res_list_t        ent_r;
  logic [CNT_W-1:0] left_r;
  logic             pop;

  assign pop       = (left_r != '0) && !out_stall;
  assign can_load  = (left_r == '0) || ((left_r == CNT_W'(1)) && !out_stall);

  assign out_valid     = (left_r != '0);
  assign out_nal_byte  = ent_r[0].data;
  assign out_nal_first = ent_r[0].first;
  assign out_nal_final = ent_r[0].fin;
  assign out_run_last  = (left_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (load) begin
      left_r <= res_in.nres;
    end else if (pop) begin
      left_r <= left_r - CNT_W'(1);
    end
  end

  // shift down so the head is always entry zero
  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= res_in.res;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

  a_left_max: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= CNT_W'(MAX_RES))
    else $error("result buffer count out of range");

  a_load_safe: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ((left_r == '0) || (left_r == CNT_W'(1) && !out_stall)))
    else $error("load while results still pending");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> (left_r == $past(left_r) - CNT_W'(1)))
    else $error("result count did not advance");

endmodule

// ===== rtl/annexb_nal_splitter.sv =====
// ----------------------------------------------------------------------------
// annexb_nal_splitter: Annex B start code NAL splitter
// Splits a byte stream at 00 00 01 / 00 00 00 01 start codes into NAL bytes
// with first/last marks.
// ----------------------------------------------------------------------------
// Results of a request are registered and appear on the output in the cycle
// after accept. Throughput: one byte per cycle unless in_stall; a byte other
// than a buffer end yields at most one result. A buffer-end byte yields up to
// five results, drained one per cycle unless out_stall, stalling the input.
// Reset: rst_n synchronous, active low; clears the scan state and the
// result buffer count, no clearing pass.
// ----------------------------------------------------------------------------
module annexb_nal_splitter
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_buffer_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_nal_byte,
  output logic       out_nal_first,
  output logic       out_nal_final,
  output logic       out_run_last
);

  // Scan state: up to three undecided bytes, the NAL flag and the held byte.
  // The held byte waits until the next decision tells whether it is final.
  scan_st_t  st_r;
  scan_st_t  st_nxt;
  res_pack_t res;
  logic      can_load;
  logic      in_accept;

  // Stall while more than one result is pending or the last one is held by
  // out_stall, so a new request can overlap the last result leaving.
  assign in_stall  = !can_load;
  assign in_accept = in_valid && can_load;

  anbs_scan u_scan (
    .st         (st_r),
    .data_byte  (in_data_byte),
    .buffer_end (in_buffer_end),
    .st_nxt     (st_nxt),
    .res_out    (res)
  );

  // Hold the scan state; advance only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_accept) begin
      st_r <= st_nxt;
    end
  end

  // Load the result list of each accepted request that produced results.
  anbs_outbuf u_outbuf (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (in_accept && (res.nres != '0)),
    .res_in        (res),
    .can_load      (can_load),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_nal_byte  (out_nal_byte),
    .out_nal_first (out_nal_first),
    .out_nal_final (out_nal_final),
    .out_run_last  (out_run_last)
  );

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt < CNT_W'(WIN_DEPTH))
    else $error("lookahead window overfilled");

  a_held_in_nal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.hv |-> st_r.in_nal)
    else $error("held byte outside a NAL");

  a_end_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_buffer_end) |=> (st_r.cnt == '0 && !st_r.in_nal && !st_r.hv))
    else $error("state not cleared after buffer end");

  a_mid_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !in_buffer_end) |-> (res.nres <= CNT_W'(1)))
    else $error("more than one result for a mid-buffer byte");

endmodule

// ===== test/nal_stream_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nal_stream_checker: scoreboard for the Annex B NAL splitter
// Watches the byte and NAL channels, predicts the NAL bytes that each
// accepted request causes and compares them in order with what comes out.
// ----------------------------------------------------------------------------
module nal_stream_checker
  import anbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_buffer_end,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_nal_byte,
  input  logic       out_nal_first,
  input  logic       out_nal_final,
  input  logic       out_run_last,
  output int         err_count,
  output int         nal_bytes_owed
);

  localparam int SC3_LEN = 3;
  localparam int SC4_LEN = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       fin;
    logic       run_last;
  } nal_out_t;

  // Scan state of the splitter as seen from outside.
  logic [7:0] win [WIN_DEPTH];
  int         win_fill;
  bit         in_unit;
  logic [7:0] held;
  bit         held_ok;
  bit         held_first;

  nal_out_t   step_out[$];
  nal_out_t   owed_q[$];
  int         errs = 0;

  function automatic void push_out(logic [7:0] b, bit first, bit fin);
    nal_out_t r;
    r.data     = b;
    r.first    = first;
    r.fin      = fin;
    r.run_last = 1'b0;
    step_out.push_back(r);
  endfunction

  function automatic void shift_win(int k);
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (int i = 0; i + k < win_fill; i++) win[i] = win[i + k];
      win_fill -= k;
    end
  endfunction

  function automatic void close_unit();
    if (held_ok) push_out(held, held_first, 1'b1);
    held_ok    = 1'b0;
    held_first = 1'b0;
    held       = 8'h00;
  endfunction

  function automatic void start_code(int len);
    close_unit();
    in_unit = 1'b1;
    shift_win(len);
  endfunction

  // Oldest window byte is payload: release the held byte as non-final.
  function automatic void take_oldest();
    if (in_unit) begin
      if (held_ok) push_out(held, held_first, 1'b0);
      held_first = !held_ok;
      held       = win[0];
      held_ok    = 1'b1;
    end
    shift_win(1);
  endfunction

  function automatic bit short_code_at_head();
    return win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h01;
  endfunction

  function automatic void clear_state();
    foreach (win[i]) win[i] = 8'h00;
    win_fill   = 0;
    in_unit    = 1'b0;
    held       = 8'h00;
    held_ok    = 1'b0;
    held_first = 1'b0;
  endfunction

  function automatic void predict_nal_bytes(logic [7:0] b, logic last);
    nal_out_t r;
    step_out.delete();
    if (win_fill >= WIN_DEPTH) win_fill = WIN_DEPTH - 1;
    win[win_fill] = b;
    win_fill++;
    if (win_fill == WIN_DEPTH) begin
      if (short_code_at_head()) begin
        start_code(SC3_LEN);
      end else if (win[0] == 8'h00 && win[1] == 8'h00 && win[2] == 8'h00 &&
                   win[3] == 8'h01) begin
        start_code(SC4_LEN);
      end else begin
        take_oldest();
      end
    end
    // Flush: only the short code can still match with three bytes left.
    if (last) begin
      if (win_fill >= SC3_LEN) begin
        if (short_code_at_head()) start_code(SC3_LEN);
        else take_oldest();
      end
      while (win_fill > 0) take_oldest();
      close_unit();
      clear_state();
    end
    if (step_out.size() > 0) begin
      r = step_out.pop_back();
      r.run_last = 1'b1;
      step_out.push_back(r);
    end
    foreach (step_out[i]) owed_q.push_back(step_out[i]);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk) begin
    nal_out_t want;
    if (!rst_n) begin
      clear_state();
      owed_q.delete();
    end else begin
      // Compare first: results never appear in the cycle of their request.
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) begin
          $error("unexpected result: nal_byte 'h%0h first %0d final %0d", out_nal_byte,
                 out_nal_first, out_nal_final);
          errs++;
        end else begin
          want = owed_q.pop_front();
          check_field("nal_byte", want.data, out_nal_byte);
          check_field("nal_first", want.first, out_nal_first);
          check_field("nal_final", want.fin, out_nal_final);
          check_field("run_last", want.run_last, out_run_last);
        end
      end
      if (in_valid && !in_stall) predict_nal_bytes(in_data_byte, in_buffer_end);
    end
    err_count      <= errs;
    nal_bytes_owed <= owed_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: byte-stream test of the Annex B NAL splitter
// Feeds directed and random buffers with start codes, junk and flush cases,
// varies idling on both channels and gives the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  typedef logic [7:0] byte_q_t[$];

  logic       clk           = 1'b0;
  logic       rst_n         = 1'b0;
  logic       in_valid      = 1'b0;
  logic [7:0] in_data_byte  = 8'h00;
  logic       in_buffer_end = 1'b0;
  logic       out_stall     = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_nal_byte;
  logic       out_nal_first;
  logic       out_nal_final;
  logic       out_run_last;

  int   fails;
  int   owed;
  int   sent          = 0;
  int   send_idle_pct = 0;   // read only by the stimulus process
  int   stall_pct     = 0;
  logic hold_off      = 1'b0;

  always #10 clk = ~clk;

  annexb_nal_splitter dut (.*);

  nal_stream_checker chk (.*, .err_count(fails), .nal_bytes_owed(owed));

  // Receiver: stall at random, or solidly while a hold-off is running.
  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < stall_pct);
  end

  // Hold the result channel for a long stretch while requests keep coming,
  // so the result buffer fills and the splitter has to stall its input.
  initial begin
    wait (sent >= 380);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (80) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Offer one byte; idle first at random, then hold it until accepted.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_buffer_end <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Send a whole buffer, flagging its final byte as the buffer end.
  task automatic send_buffer(input byte_q_t bytes);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  // Bias toward 00 and 01 so that start codes also form by chance.
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'h00;
    if (r < 35) return 8'h01;
    return 8'($urandom_range(255));
  endfunction

  // Mostly well-formed buffers: optional junk, then NAL units each behind a
  // three- or four-byte start code, some empty, some with a broken code.
  // One buffer in ten is plain noise.
  task automatic random_buffer();
    byte_q_t q;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 12)) q.push_back(pick_byte());
    end else begin
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 3)) q.push_back(pick_byte());
      end
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(2) == 0) q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(8'h00);
        q.push_back(($urandom_range(7) == 0) ? 8'h02 : 8'h01);
        repeat ($urandom_range(0, 6)) q.push_back(pick_byte());
      end
    end
    send_buffer(q);
  endtask

  initial begin
    byte_q_t q;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles now and then, receiver stalls most cycles.
    send_idle_pct = 20;
    stall_pct    <= 59;

    // Short and long start codes, extreme byte values, payload 00 at the end.
    q = {8'h00, 8'h00, 8'h01, 8'hAA, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00};
    send_buffer(q);
    // Junk ahead of the first start code is dropped; an empty NAL is skipped.
    q = {8'h7F, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01, 8'h80};
    send_buffer(q);
    // Buffers too short to hold a start code yield nothing.
    q = {8'h00, 8'h00};
    send_buffer(q);
    q = {8'h01};
    send_buffer(q);
    // A short start code in the last three bytes still closes the NAL.
    q = {8'h00, 8'h00, 8'h01, 8'h55, 8'h00, 8'h00, 8'h01};
    send_buffer(q);

    while (sent < 180) random_buffer();

    // Phase two: the other way round.
    send_idle_pct = 59;
    stall_pct    <= 20;
    while (sent < 340) random_buffer();

    // Phase three: full rate on both sides; the hold-off lands here.
    send_idle_pct = 0;
    stall_pct    <= 0;
    while (sent < 460) random_buffer();

    in_valid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    // Keep draining to catch any stray result.
    repeat (8) @(posedge clk);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== annexb_nal_splitter.f =====
rtl/anbs_pkg.sv
rtl/anbs_scan.sv
rtl/anbs_outbuf.sv
rtl/annexb_nal_splitter.sv
test/nal_stream_checker.sv
test/tb_top.sv
